// ===== hdl/rgbls_pkg.sv =====
// ----------------------------------------------------------------------------
// rgbls_pkg
// Shared types and constants for the RGB LED strip serializer.
// ----------------------------------------------------------------------------
package rgbls_pkg;

  typedef enum logic [1:0] {
    REQ_WRITE   = 2'd0,
    REQ_REFRESH = 2'd1,
    REQ_TICK    = 2'd2,
    REQ_NOP     = 2'd3
  } req_code_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BUSY  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2,
    PH_GAP  = 2'd3
  } phase_t;

  localparam logic [1:0] CFG_SHORT = 2'd0;
  localparam logic [1:0] CFG_LONG  = 2'd1;
  localparam logic [1:0] CFG_GAP   = 2'd2;

  localparam logic [11:0] SHORT_RST = 12'd20;
  localparam logic [11:0] LONG_RST  = 12'd43;
  localparam logic [15:0] GAP_RST   = 16'd3300;

  typedef struct packed {
    logic [1:0] req_type;
    logic [6:0] led_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [6:0] led_count;
  } req_t;

  typedef struct packed {
    logic       line_level;
    logic       busy_res;
    logic       frame_done;
    logic [1:0] status;
  } res_t;

  typedef struct packed {
    logic [11:0] short_ticks;
    logic [11:0] long_ticks;
    logic [15:0] gap_ticks;
  } cfg_t;

endpackage

// ===== hdl/rgbls_ram.sv =====
// ----------------------------------------------------------------------------
// rgbls_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rgbls_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/rgbls_core.sv =====
// ----------------------------------------------------------------------------
// rgbls_core
// Pixel store and waveform state machine; one request per advance.
// ----------------------------------------------------------------------------
module rgbls_core #(
  parameter int MAX_LEDS = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           advance,
  input  rgbls_pkg::req_t req,
  input  rgbls_pkg::cfg_t cfg,
  output rgbls_pkg::res_t res
);

  localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int CW = $clog2(MAX_LEDS + 1);

  rgbls_pkg::phase_t phase_r, phase_nxt;
  logic [15:0]   ticks_r, ticks_nxt, ticks_inc;
  logic [CW-1:0] led_r, led_nxt, led_inc, count_r, count_nxt, cnt_sat;
  logic [1:0]    comp_r, comp_nxt, comp_inc;
  logic [2:0]    bit_r, bit_nxt;
  logic          line_r, line_nxt;
  logic [MAX_LEDS-1:0] valid_r;
  logic          rd_valid_r;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [23:0]   rd_data, word;
  logic [7:0]    cur_byte;
  logic          cur_bit, we, idle, done;
  logic          hi_end, lo_end, gap_end, last_bit;
  rgbls_pkg::status_t status;

  assign idle      = (phase_r == rgbls_pkg::PH_IDLE);
  assign ticks_inc = ticks_r + 16'd1;
  assign word      = rd_valid_r ? rd_data : 24'd0;

  always_comb begin
    case (comp_r)
      2'd0:    cur_byte = word[23:16];
      2'd1:    cur_byte = word[15:8];
      default: cur_byte = word[7:0];
    endcase
  end

  assign cur_bit = cur_byte[bit_r];
  assign hi_end  = ticks_inc >= {4'd0, cur_bit ? cfg.long_ticks : cfg.short_ticks};
  assign lo_end  = ticks_inc >= {4'd0, cur_bit ? cfg.short_ticks : cfg.long_ticks};
  assign gap_end = ticks_inc >= cfg.gap_ticks;

  assign comp_inc = (comp_r == 2'd2) ? 2'd0 : comp_r + 2'd1;
  assign led_inc  = (comp_r == 2'd2) ? led_r + CW'(1) : led_r;
  assign last_bit = (bit_r == 3'd0) && (comp_inc == 2'd0) && (led_inc == count_r);

  assign cnt_sat = (int'(req.led_count) > MAX_LEDS) ? CW'(MAX_LEDS) : CW'(req.led_count);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    case (req.req_type)
      rgbls_pkg::REQ_REFRESH: begin
        if (idle) begin
          phase_nxt = (cnt_sat == '0) ? rgbls_pkg::PH_GAP : rgbls_pkg::PH_HIGH;
        end
      end
      rgbls_pkg::REQ_TICK: begin
        case (phase_r)
          rgbls_pkg::PH_HIGH: if (hi_end) phase_nxt = rgbls_pkg::PH_LOW;
          rgbls_pkg::PH_LOW: begin
            if (lo_end) phase_nxt = last_bit ? rgbls_pkg::PH_GAP : rgbls_pkg::PH_HIGH;
          end
          rgbls_pkg::PH_GAP: if (gap_end) phase_nxt = rgbls_pkg::PH_IDLE;
          default: phase_nxt = phase_r;
        endcase
      end
      default: phase_nxt = phase_r;
    endcase
  end

  // counters, line and result
  always_comb begin
    ticks_nxt = ticks_r;
    led_nxt   = led_r;
    comp_nxt  = comp_r;
    bit_nxt   = bit_r;
    count_nxt = count_r;
    line_nxt  = line_r;
    status    = rgbls_pkg::ST_OK;
    done      = 1'b0;
    we        = 1'b0;
    case (req.req_type)
      rgbls_pkg::REQ_WRITE: begin
        if (!idle) begin
          status = rgbls_pkg::ST_BUSY;
        end else if (req.led_index == 7'd0 || int'(req.led_index) > MAX_LEDS) begin
          status = rgbls_pkg::ST_RANGE;
        end else begin
          we = 1'b1;
        end
      end
      rgbls_pkg::REQ_REFRESH: begin
        if (!idle) begin
          status = rgbls_pkg::ST_BUSY;
        end else begin
          count_nxt = cnt_sat;
          led_nxt   = '0;
          comp_nxt  = 2'd0;
          bit_nxt   = 3'd7;
          ticks_nxt = 16'd0;
          line_nxt  = (cnt_sat != '0);
        end
      end
      rgbls_pkg::REQ_TICK: begin
        case (phase_r)
          rgbls_pkg::PH_HIGH: begin
            ticks_nxt = hi_end ? 16'd0 : ticks_inc;
            if (hi_end) line_nxt = 1'b0;
          end
          rgbls_pkg::PH_LOW: begin
            ticks_nxt = lo_end ? 16'd0 : ticks_inc;
            if (lo_end) begin
              if (bit_r != 3'd0) begin
                bit_nxt = bit_r - 3'd1;
              end else begin
                bit_nxt  = 3'd7;
                comp_nxt = comp_inc;
                led_nxt  = led_inc;
              end
              line_nxt = !last_bit;
            end
          end
          rgbls_pkg::PH_GAP: begin
            ticks_nxt = gap_end ? 16'd0 : ticks_inc;
            if (gap_end) begin
              line_nxt = 1'b0;
              done     = 1'b1;
            end
          end
          default: ticks_nxt = ticks_r;
        endcase
      end
      default: status = rgbls_pkg::ST_OK;
    endcase
  end

  assign res.line_level = line_nxt;
  assign res.busy_res   = (phase_nxt != rgbls_pkg::PH_IDLE);
  assign res.frame_done = done;
  assign res.status     = status;

  // read address follows the LED that the next request will use
  always_comb begin
    if (advance) begin
      rd_addr = (int'(led_nxt) >= MAX_LEDS) ? '0 : AW'(led_nxt);
    end else begin
      rd_addr = (int'(led_r) >= MAX_LEDS) ? '0 : AW'(led_r);
    end
  end

  assign wr_addr = AW'(req.led_index - 7'd1);

  rgbls_ram #(
    .WIDTH (24),
    .DEPTH (MAX_LEDS)
  ) u_store (
    .clk   (clk),
    .we    (advance && we),
    .waddr (wr_addr),
    .wdata ({req.green, req.red, req.blue}),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= rgbls_pkg::PH_IDLE;
      ticks_r    <= 16'd0;
      led_r      <= '0;
      comp_r     <= 2'd0;
      bit_r      <= 3'd7;
      count_r    <= '0;
      line_r     <= 1'b0;
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= valid_r[rd_addr];
      if (advance) begin
        phase_r <= phase_nxt;
        ticks_r <= ticks_nxt;
        led_r   <= led_nxt;
        comp_r  <= comp_nxt;
        bit_r   <= bit_nxt;
        count_r <= count_nxt;
        line_r  <= line_nxt;
        if (we) begin
          valid_r[wr_addr] <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hdl/rgb_led_strip_serializer.sv =====
// ----------------------------------------------------------------------------
// rgb_led_strip_serializer
// WS2812-style strip driver: pixel store, timing registers and serializer.
// ----------------------------------------------------------------------------
// Each input transaction passes the input register, then the result register.
// Throughput: one transaction per cycle unless out_ready holds the output; the
// pixel store read is prefetched, as the store RAM has a registered read port.
// Reset: synchronous, active low; timing registers to defaults, pixels read
// dark through per-entry valid flags, no clearing pass.
module rgb_led_strip_serializer #(
  parameter int MAX_LEDS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [6:0]  in_led_index,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [6:0]  in_led_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_line_level,
  output logic        out_busy_res,
  output logic        out_frame_done,
  output logic [1:0]  out_status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  rgbls_pkg::req_t req_r;
  rgbls_pkg::res_t res, res_r;
  rgbls_pkg::cfg_t cfg_r;
  logic in_valid_r, out_valid_r, advance;

  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cfg_r.short_ticks <= rgbls_pkg::SHORT_RST;
      cfg_r.long_ticks  <= rgbls_pkg::LONG_RST;
      cfg_r.gap_ticks   <= rgbls_pkg::GAP_RST;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        case (cfg_index)
          rgbls_pkg::CFG_SHORT: cfg_r.short_ticks <= cfg_data[11:0];
          rgbls_pkg::CFG_LONG:  cfg_r.long_ticks  <= cfg_data[11:0];
          rgbls_pkg::CFG_GAP:   cfg_r.gap_ticks   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req_r <= '{req_type:  in_req_type,  led_index: in_led_index,
                 red:       in_red,       green:     in_green,
                 blue:      in_blue,      led_count: in_led_count};
    end
    if (advance) begin
      res_r <= res;
    end
  end

  rgbls_core #(
    .MAX_LEDS (MAX_LEDS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .req     (req_r),
    .cfg     (cfg_r),
    .res     (res)
  );

  assign out_valid      = out_valid_r;
  assign out_line_level = res_r.line_level;
  assign out_busy_res   = res_r.busy_res;
  assign out_frame_done = res_r.frame_done;
  assign out_status     = res_r.status;

endmodule
